FILE: rtl/tri_pkg.sv
// Shared types, codes and helpers for the triangle wave channel.
// No dependencies; imported by tri_timer, triangle_wave_channel and the bench files.
`timescale 1ns / 1ps

package tri_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  localparam logic [1:0] RegCtrl     = 2'd0;
  localparam logic [1:0] RegSweep    = 2'd1;
  localparam logic [1:0] RegPeriodLo = 2'd2;
  localparam logic [1:0] RegPeriodHi = 2'd3;

  // Largest cycle count honored by one run item.
  localparam logic [7:0] MaxRun = 8'd255;

  typedef struct packed {
    logic       start;
    logic [7:0] cycles;
  } tmr_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic step_adv;
  } tmr_stat_t;

  // Signed sequencer output: 15,13,..,-15 then -15,..,15, zero when muted.
  function automatic logic signed [4:0] tri_sample(logic [4:0] step, logic [10:0] period);
    logic [4:0] two_s;
    logic [4:0] val;
    two_s = {step[3:0], 1'b0};
    if (period <= 11'd1) begin
      val = 5'd0;
    end else if (!step[4]) begin
      val = 5'd15 - two_s;
    end else begin
      val = two_s - 5'd15;
    end
    return $signed(val);
  endfunction

endpackage

FILE: rtl/tri_timer.sv
// Down timer with one shared adder: subtracts the run length, then adds
// the reload value once per cycle while the timer is not positive.
// Depends on tri_pkg.
`timescale 1ns / 1ps

module tri_timer import tri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tmr_ctrl_t   ctrl_i,
  input  logic [11:0] reload_i,
  output tmr_stat_t   stat_o
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SUB  = 3'b010,
    T_ADD  = 3'b100
  } tstate_e;

  tstate_e            state_q, state_d;
  logic signed [12:0] timer_q, timer_d;
  logic [7:0]         cycles_q, cycles_d;
  logic [12:0]        opnd;
  logic [12:0]        sum;
  logic               is_sub;
  logic               nonpos;

  assign is_sub = (state_q == T_SUB);
  assign opnd   = is_sub ? ~{5'd0, cycles_q} : {1'b0, reload_i};
  assign sum    = timer_q + opnd + {12'd0, is_sub};
  assign nonpos = timer_q[12] || (timer_q == 13'sd0);

  always_comb begin
    state_d  = state_q;
    timer_d  = timer_q;
    cycles_d = cycles_q;
    stat_o   = '0;
    case (state_q)
      T_IDLE: begin
        if (ctrl_i.start) begin
          cycles_d = ctrl_i.cycles;
          state_d  = T_SUB;
        end
      end
      T_SUB: begin
        stat_o.busy = 1'b1;
        timer_d     = $signed(sum);
        state_d     = T_ADD;
      end
      T_ADD: begin
        stat_o.busy = 1'b1;
        if (nonpos) begin
          timer_d         = $signed(sum);
          stat_o.step_adv = 1'b1;
        end else begin
          stat_o.done = 1'b1;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      timer_q  <= '0;
      cycles_q <= '0;
    end else begin
      state_q  <= state_d;
      timer_q  <= timer_d;
      cycles_q <= cycles_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> !timer_q[12] && timer_q != 13'sd0 && timer_q <= 13'sd2048)
    else $error("timer left its range at the end of a run");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start && state_q == T_IDLE |=> stat_o.busy)
    else $error("timer did not start");

  a_sub_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_SUB |=> state_q == T_ADD)
    else $error("timer stayed in the subtract step");
`endif

endmodule

FILE: rtl/triangle_wave_channel.sv
// Top level of the triangle wave channel: register file, linear counter,
// sequencer step and output register. Depends on tri_pkg and tri_timer.
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  func_i reg_select_i write_data_i run_cycles_i
//                                   length_active_i
// out      out_valid_o / out_stall_i sample_o linear_nonzero_o
// Writes, ticks and unknown codes go from accept through S_DONE to the output register.
// A run item makes n timer reloads, where n is 0 to 256; the shared timer
// adder performs one reload per cycle.
// Reset clears all state but the sample and linear_nonzero output registers.
// A stalled output holds the block before it accepts the next item.
`timescale 1ns / 1ps

module triangle_wave_channel import tri_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [1:0]        reg_select_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        run_cycles_i,
  input  logic              length_active_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [4:0] sample_o,
  output logic              linear_nonzero_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              control_q, control_d;
  logic [6:0]        lin_reload_q, lin_reload_d;
  logic [10:0]       period_q, period_d;
  logic [4:0]        step_q, step_d;
  logic [6:0]        lin_cnt_q, lin_cnt_d;
  logic              reload_pend_q, reload_pend_d;
  logic              gate_q, gate_d;
  logic              out_valid_q, out_valid_d;
  logic signed [4:0] sample_q, sample_d;
  logic              lin_nz_q, lin_nz_d;
  logic              accept;
  logic [7:0]        cycles_eff;
  tmr_ctrl_t         tmr_ctrl;
  tmr_stat_t         tmr_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cycles_eff = (run_cycles_i > MaxRun) ? MaxRun : run_cycles_i;

  assign tmr_ctrl.start  = accept && (func_i == FUNC_RUN);
  assign tmr_ctrl.cycles = cycles_eff;

  tri_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tmr_ctrl),
    .reload_i ({1'b0, period_q} + 12'd1),
    .stat_o   (tmr_stat)
  );

  always_comb begin
    state_d       = state_q;
    control_d     = control_q;
    lin_reload_d  = lin_reload_q;
    period_d      = period_q;
    step_d        = step_q;
    lin_cnt_d     = lin_cnt_q;
    reload_pend_d = reload_pend_q;
    gate_d        = gate_q;
    out_valid_d   = out_valid_q && out_stall_i;
    sample_d      = sample_q;
    lin_nz_d      = lin_nz_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          case (func_i)
            FUNC_WRITE: begin
              case (reg_select_i)
                RegCtrl: begin
                  control_d    = write_data_i[7];
                  lin_reload_d = write_data_i[6:0];
                end
                RegPeriodLo: begin
                  period_d[7:0] = write_data_i;
                end
                RegPeriodHi: begin
                  period_d[10:8] = write_data_i[2:0];
                  reload_pend_d  = 1'b1;
                end
                default: begin
                end
              endcase
            end
            FUNC_RUN: begin
              gate_d  = (lin_cnt_q != 7'd0) && length_active_i;
              state_d = S_RUN;
            end
            FUNC_TICK: begin
              if (reload_pend_q) begin
                lin_cnt_d = lin_reload_q;
              end else if (lin_cnt_q != 7'd0) begin
                lin_cnt_d = lin_cnt_q - 7'd1;
              end
              if (!control_q) begin
                reload_pend_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        if (tmr_stat.step_adv && gate_q) begin
          step_d = step_q + 5'd1;
        end
        if (tmr_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          sample_d    = tri_sample(step_q, period_q);
          lin_nz_d    = (lin_cnt_q != 7'd0);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      control_q     <= 1'b0;
      lin_reload_q  <= '0;
      period_q      <= '0;
      step_q        <= '0;
      lin_cnt_q     <= '0;
      reload_pend_q <= 1'b0;
      gate_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      control_q     <= control_d;
      lin_reload_q  <= lin_reload_d;
      period_q      <= period_d;
      step_q        <= step_d;
      lin_cnt_q     <= lin_cnt_d;
      reload_pend_q <= reload_pend_d;
      gate_q        <= gate_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    lin_nz_q <= lin_nz_d;
  end

  assign out_valid_o      = out_valid_q;
  assign sample_o         = sample_q;
  assign linear_nonzero_o = lin_nz_q;

`ifndef ASSERT_OFF
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_stat.done |-> state_q == S_RUN)
    else $error("timer finished outside a run item");

  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_stat.busy |-> state_q == S_RUN)
    else $error("timer busy while the channel is not running");

  a_sample_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o == 5'sd0 || sample_o[0])
    else $error("sample is neither muted nor an odd level");

  a_step_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_RUN |=> $stable(step_q))
    else $error("sequencer stepped outside a run item");
`endif

endmodule

FILE: bench/tri_channel_checker.sv
// Checker for the triangle wave channel: predicts each result from accepted items
// and compares it with what the output channel delivers. Depends on tri_pkg.
`timescale 1ns / 1ps

module tri_channel_checker import tri_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        func_i,
  input  logic [1:0]        reg_select_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        run_cycles_i,
  input  logic              length_active_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic signed [4:0] sample_i,
  input  logic              linear_nonzero_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [4:0] sample;
    logic       lin_nz;
  } tri_result_t;

  tri_result_t expected_results[$];

  logic        ctrl_flag;
  logic [6:0]  lin_reload;
  logic [10:0] period;
  int          down_timer;
  logic [4:0]  seq_step;
  logic [6:0]  lin_count;
  logic        reload_pend;
  int          mismatches = 0;

  function automatic logic [4:0] predicted_sample();
    int v;
    if (period <= 11'd1) begin
      v = 0;
    end else if (seq_step < 5'd16) begin
      v = 15 - 2 * int'(seq_step);
    end else begin
      v = 2 * int'(seq_step) - 47;
    end
    return v[4:0];
  endfunction

  task automatic advance_channel(logic [1:0] f, logic [1:0] sel, logic [7:0] data,
                                 logic [7:0] cyc, logic len);
    int t;
    int adds;
    int reload;
    case (f)
      FUNC_WRITE: begin
        case (sel)
          RegCtrl: begin
            ctrl_flag  = data[7];
            lin_reload = data[6:0];
          end
          RegPeriodLo: period[7:0] = data;
          RegPeriodHi: begin
            period[10:8] = data[2:0];
            reload_pend  = 1'b1;
          end
          default: ;
        endcase
      end
      FUNC_RUN: begin
        reload = int'(period) + 1;
        t = down_timer - int'(cyc);
        if (t <= 0) begin
          adds = (-t) / reload + 1;
          t = t + adds * reload;
          if (lin_count != 7'd0 && len) seq_step = seq_step + adds[4:0];
        end
        down_timer = t;
      end
      FUNC_TICK: begin
        if (reload_pend) begin
          lin_count = lin_reload;
        end else if (lin_count != 7'd0) begin
          lin_count = lin_count - 7'd1;
        end
        if (!ctrl_flag) reload_pend = 1'b0;
      end
      default: ;
    endcase
    expected_results.push_back('{predicted_sample(), lin_count != 7'd0});
  endtask

  task automatic report(string what, int want, int got);
    $display("mismatch at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tri_result_t want;
    if (!rst_ni) begin
      ctrl_flag   = 1'b0;
      lin_reload  = '0;
      period      = '0;
      down_timer  = 0;
      seq_step    = '0;
      lin_count   = '0;
      reload_pend = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_channel(func_i, reg_select_i, write_data_i, run_cycles_i, length_active_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected item, sample", 0, int'(sample_i));
        end else begin
          want = expected_results.pop_front();
          if (sample_i !== $signed(want.sample)) begin
            report("sample", int'($signed(want.sample)), int'(sample_i));
          end
          if (linear_nonzero_i !== want.lin_nz) begin
            report("linear_nonzero", int'(want.lin_nz), int'(linear_nonzero_i));
          end
        end
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= mismatches;
  end

endmodule

FILE: bench/tb_triangle_wave_channel.sv
// Top of the triangle wave channel testbench: clock, reset, directed and random
// items, output stalls and the verdict. Depends on tri_pkg, triangle_wave_channel and tri_channel_checker.
`timescale 1ns / 1ps

module tb_triangle_wave_channel import tri_pkg::*; ();

  localparam logic [1:0] FuncUnknown = 2'd3;
  localparam int CycleLimit = 10_000_000;
  localparam int ItemTarget = 1950;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        func = '0;
  logic [1:0]        reg_select = '0;
  logic [7:0]        write_data = '0;
  logic [7:0]        run_cycles = '0;
  logic              length_active = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [4:0] sample;
  logic              linear_nonzero;
  int                fail_count;
  int                pending;

  int items_sent = 0;
  bit no_gaps = 1'b0;

  always #1 clk_i = ~clk_i;

  triangle_wave_channel uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .reg_select_i    (reg_select),
    .write_data_i    (write_data),
    .run_cycles_i    (run_cycles),
    .length_active_i (length_active),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_o        (sample),
    .linear_nonzero_o(linear_nonzero)
  );

  tri_channel_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .func_i          (func),
    .reg_select_i    (reg_select),
    .write_data_i    (write_data),
    .run_cycles_i    (run_cycles),
    .length_active_i (length_active),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .sample_i        (sample),
    .linear_nonzero_i(linear_nonzero),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  function automatic int idle_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(logic [1:0] f, logic [1:0] sel, logic [7:0] data,
                           logic [7:0] cyc, logic len);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    func          <= f;
    reg_select    <= sel;
    write_data    <= data;
    run_cycles    <= cyc;
    length_active <= len;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] sel, logic [7:0] data);
    send_item(FUNC_WRITE, sel, data, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_for(logic [7:0] cyc, logic len);
    send_item(FUNC_RUN, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), cyc, len);
  endtask

  task automatic quarter_tick();
    send_item(FUNC_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] random_cycles();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(0, 255));
    if (r < 8) return 8'($urandom_range(0, 8));
    return 8'($urandom_range(200, 255));
  endfunction

  // One setup of control, period and linear counter, then a burst of runs, ticks and register writes.
  task automatic random_sequence();
    logic [7:0] ctrl_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    int steps;
    int r;
    ctrl_byte[7]   = 1'($urandom_range(0, 1));
    ctrl_byte[6:0] = 7'($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(0, 127));
    lo_byte = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    hi_byte = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 7) hi_byte[2:0] = 3'd0;
    write_reg(RegCtrl, ctrl_byte);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(RegPeriodLo, lo_byte);
      write_reg(RegPeriodHi, hi_byte);
    end else begin
      write_reg(RegPeriodHi, hi_byte);
      write_reg(RegPeriodLo, lo_byte);
    end
    quarter_tick();
    steps = $urandom_range(4, 20);
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        run_for(random_cycles(), $urandom_range(0, 9) != 0);
      end else if (r < 90) begin
        quarter_tick();
      end else if (r < 95) begin
        write_reg(RegCtrl, 8'($urandom_range(0, 255)));
      end else begin
        write_reg(RegPeriodLo, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    quarter_tick();
    run_for(8'd0, 1'b1);
    send_item(FuncUnknown, 2'd3, 8'hff, 8'hff, 1'b1);
    write_reg(RegSweep, 8'hff);
    write_reg(RegCtrl, 8'hff);
    write_reg(RegPeriodLo, 8'h00);
    write_reg(RegPeriodHi, 8'h00);
    quarter_tick();
    run_for(8'd255, 1'b1);
    write_reg(RegPeriodLo, 8'h01);
    run_for(8'd200, 1'b1);
    write_reg(RegPeriodLo, 8'h02);
    run_for(8'd37, 1'b1);
    run_for(8'd100, 1'b0);
    write_reg(RegPeriodHi, 8'hff);
    run_for(8'd255, 1'b1);
    write_reg(RegPeriodLo, 8'hff);
    run_for(8'd255, 1'b1);
    write_reg(RegCtrl, 8'h00);
    quarter_tick();
    quarter_tick();
    write_reg(RegCtrl, 8'h03);
    write_reg(RegPeriodHi, 8'h00);
    quarter_tick();
    quarter_tick();
    run_for(8'd255, 1'b1);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 4) != 0) begin
        random_sequence();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Output stalls in random runs, with one long hold-off that backs up the block.
  initial begin
    int cyc_count;
    int hold_left;
    int run_left;
    bit cur;
    cyc_count = 0;
    hold_left = 0;
    run_left  = 0;
    cur       = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc_count++;
      if (cyc_count == 6000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          cur = ($urandom_range(0, 2) == 0);
          if (cur) begin
            run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
          end else begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
          end
        end
        run_left--;
        out_stall <= cur;
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

endmodule
